// ===== rtl/core/hzm_pkg.sv =====
// Shared constants, types and the helper function of the half-step image zoom.
`default_nettype none
package hzm_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int MAX_LANES  = 10;
  localparam int LANE_COUNT = 10;

  localparam logic [4:0] ZF_RESET = 5'd4;
  localparam logic [4:0] ZF_3     = 5'd3;
  localparam logic [4:0] ZF_4     = 5'd4;
  localparam logic [4:0] ZF_5     = 5'd5;
  localparam logic [4:0] ZF_7     = 5'd7;
  localparam logic [4:0] ZF_9     = 5'd9;
  localparam logic [4:0] ZF_20    = 5'd20;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef struct packed {
    pix_t       tl;
    pix_t       tr;
    pix_t       bl;
    pix_t       br;
    logic [3:0] n;
    logic [2:0] h;
    logic       odd;
    logic [3:0] row;
  } hzm_job_t;

  typedef struct packed {
    logic [3:0]                 row_in_block;
    pix_t [LANE_COUNT-1:0]      lanes;
    logic                       last_row;
  } hzm_row_t;

  function automatic pix_t mean2(pix_t a, pix_t b);
    logic [PIXEL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIXEL_BITS:1];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hzm_in_if.sv =====
// Input channel carrying one 2x2 source block per transfer.
`default_nettype none
interface hzm_in_if;
  import hzm_pkg::*;

  logic valid;
  logic ready;
  pix_t top_left;
  pix_t top_right;
  pix_t bottom_left;
  pix_t bottom_right;

  modport source (output valid, output top_left, output top_right,
                  output bottom_left, output bottom_right, input ready);
  modport sink (input valid, input top_left, input top_right,
                input bottom_left, input bottom_right, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hzm_out_if.sv =====
// Result channel carrying one expanded output row per transfer.
`default_nettype none
interface hzm_out_if;
  import hzm_pkg::*;

  logic       valid;
  logic       ready;
  logic [3:0] row_in_block;
  pix_t       px_lane0;
  pix_t       px_lane1;
  pix_t       px_lane2;
  pix_t       px_lane3;
  pix_t       px_lane4;
  pix_t       px_lane5;
  pix_t       px_lane6;
  pix_t       px_lane7;
  pix_t       px_lane8;
  pix_t       px_lane9;
  logic       last_row;

  modport source (output valid, output row_in_block, output px_lane0, output px_lane1,
                  output px_lane2, output px_lane3, output px_lane4, output px_lane5,
                  output px_lane6, output px_lane7, output px_lane8, output px_lane9,
                  output last_row, input ready);
  modport sink (input valid, input row_in_block, input px_lane0, input px_lane1,
                input px_lane2, input px_lane3, input px_lane4, input px_lane5,
                input px_lane6, input px_lane7, input px_lane8, input px_lane9,
                input last_row, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hzm_row.sv =====
// Combinational generator of one output row from the held block and row index.
`default_nettype none
module hzm_row (
  input  wire hzm_pkg::hzm_job_t job,
  output hzm_pkg::hzm_row_t      row
);
  import hzm_pkg::*;

  pix_t [LANE_COUNT-1:0] top_w;
  pix_t [LANE_COUNT-1:0] bot_w;
  pix_t                  mean_t;
  pix_t                  mean_b;

  assign mean_t = mean2(job.tl, job.tr);
  assign mean_b = mean2(job.bl, job.br);

  always_comb begin
    for (int c = 0; c < LANE_COUNT; c++) begin
      if (4'(c) < {1'b0, job.h}) begin
        top_w[c] = job.tl;
        bot_w[c] = job.bl;
      end else if (4'(c) == {1'b0, job.h}) begin
        top_w[c] = mean_t;
        bot_w[c] = mean_b;
      end else begin
        top_w[c] = job.tr;
        bot_w[c] = job.br;
      end
    end
  end

  always_comb begin
    row.row_in_block = job.row;
    row.last_row     = (job.row == job.n - 4'd1);
    for (int c = 0; c < LANE_COUNT; c++) begin
      if ((4'(c) >= job.n) || (c >= MAX_LANES)) begin
        row.lanes[c] = '0;
      end else if (!job.odd) begin
        row.lanes[c] = job.tl;
      end else if (job.row < {1'b0, job.h}) begin
        row.lanes[c] = top_w[c];
      end else if (job.row == {1'b0, job.h}) begin
        row.lanes[c] = mean2(top_w[c], bot_w[c]);
      end else begin
        row.lanes[c] = bot_w[c];
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/half_step_image_zoom.sv =====
// Top level of the half-step image zoom: block register, row sequencing, output register.
// The input block is registered in the block register and each row in the output register.
// Throughput: one output row per cycle unless the output stalls; a block of side n holds
// the input until its last row moves to the output register, and the next block is taken
// in that cycle. A block under an unsupported zoom factor is taken and yields no row.
// Reset (synchronous, rst_n low) empties both stages and sets the zoom factor to 4.
`default_nettype none
module half_step_image_zoom (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_data,
  hzm_in_if.sink          in_ch,
  hzm_out_if.source       out_ch
);
  import hzm_pkg::*;

  logic [4:0] zoom_r;
  logic       busy_r;
  hzm_job_t   job_r;
  hzm_job_t   job_nxt;
  logic       out_vld_r;
  hzm_row_t   out_row_r;
  hzm_row_t   row_w;

  logic       dec_ok;
  logic       dec_odd;
  logic [3:0] dec_n;
  logic [2:0] dec_h;
  logic       adv;
  logic       in_fire;

  always_comb begin
    dec_ok  = 1'b0;
    dec_odd = 1'b0;
    dec_n   = 4'd0;
    dec_h   = 3'd0;
    unique case (zoom_r)
      ZF_3, ZF_5, ZF_7, ZF_9: begin
        dec_ok  = 1'b1;
        dec_odd = 1'b1;
        dec_n   = zoom_r[3:0];
        dec_h   = zoom_r[3:1];
      end
      default: begin
        if (!zoom_r[0] && (zoom_r >= ZF_4) && (zoom_r <= ZF_20)) begin
          dec_ok = 1'b1;
          dec_n  = zoom_r[4:1];
        end
      end
    endcase
    if (dec_n > 4'(MAX_LANES)) begin
      dec_ok = 1'b0;
    end
  end

  hzm_row u_row (
    .job (job_r),
    .row (row_w)
  );

  assign adv          = busy_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !busy_r || (adv && row_w.last_row);
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_comb begin
    job_nxt = job_r;
    if (in_fire) begin
      job_nxt.tl  = in_ch.top_left;
      job_nxt.tr  = in_ch.top_right;
      job_nxt.bl  = in_ch.bottom_left;
      job_nxt.br  = in_ch.bottom_right;
      job_nxt.n   = dec_n;
      job_nxt.h   = dec_h;
      job_nxt.odd = dec_odd;
      job_nxt.row = 4'd0;
    end else if (adv) begin
      job_nxt.row = job_r.row + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (adv) begin
      out_row_r <= row_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r    <= ZF_RESET;
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        zoom_r <= cfg_data;
      end
      if (in_fire) begin
        busy_r <= dec_ok;
      end else if (adv && row_w.last_row) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.row_in_block = out_row_r.row_in_block;
  assign out_ch.px_lane0     = out_row_r.lanes[0];
  assign out_ch.px_lane1     = out_row_r.lanes[1];
  assign out_ch.px_lane2     = out_row_r.lanes[2];
  assign out_ch.px_lane3     = out_row_r.lanes[3];
  assign out_ch.px_lane4     = out_row_r.lanes[4];
  assign out_ch.px_lane5     = out_row_r.lanes[5];
  assign out_ch.px_lane6     = out_row_r.lanes[6];
  assign out_ch.px_lane7     = out_row_r.lanes[7];
  assign out_ch.px_lane8     = out_row_r.lanes[8];
  assign out_ch.px_lane9     = out_row_r.lanes[9];
  assign out_ch.last_row     = out_row_r.last_row;

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (job_r.row < job_r.n))
    else $error("row index outside the block");

  a_take_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && busy_r) |-> (job_r.row == job_r.n - 4'd1))
    else $error("new block taken before the last row was issued");

  a_rows_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_row) |=>
      (out_vld_r && (out_ch.row_in_block == 4'($past(out_ch.row_in_block) + 4'd1))))
    else $error("rows of a block not issued back to back in order");

endmodule
`default_nettype wire
